// ===== hdl/psve_pkg.sv =====
package psve_pkg;

   localparam int VOICE_COUNT_DEFAULT     = 4;
   localparam int PHASE_BITS_DEFAULT      = 24;
   localparam int SINE_TABLE_BITS_DEFAULT = 10;

   localparam int PITCH_W     = 24;
   localparam int LEVEL_W     = 16;
   localparam int SAMPLE_W    = 16;
   localparam int COUNT_W     = 3;
   localparam int MODE_W      = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [MODE_W-1:0] MODE_NOTE_ON  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NOTE_OFF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TICK     = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ATTACK_STEP   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_STEP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SILENCE_LEVEL = 2'd2;

   localparam logic [LEVEL_W-1:0] ATTACK_STEP_RESET   = 16'd131;
   localparam logic [LEVEL_W-1:0] RELEASE_STEP_RESET  = 16'd197;
   localparam logic [LEVEL_W-1:0] SILENCE_LEVEL_RESET = 16'd66;
   localparam logic [LEVEL_W-1:0] LEVEL_FULL          = 16'hFFFF;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

   typedef struct packed {
      logic [MODE_W-1:0]  mode;
      logic [PITCH_W-1:0] pitch_step;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [COUNT_W-1:0]         active_voices;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic mul_en;
      logic acc_en;
   } mac_ctrl_type;

   function automatic logic [15:0] sine_quarter(input int unsigned pos,
                                                input int unsigned tbl_bits);
      longint unsigned u;
      longint unsigned u2;
      longint unsigned inner;
      longint unsigned p;
      u     = longint'(pos) << (16 - (tbl_bits - 2));
      u2    = (u * u) >> 16;
      inner = 64'd42257 - ((u2 * 64'd4849) >> 16);
      p     = (u * (64'd102944 - ((u2 * inner) >> 16))) >> 16;
      p     = (p + 64'd1) >> 1;
      if (p > 64'd32767)
         p = 64'd32767;
      return p[15:0];
   endfunction

endpackage

// ===== hdl/polyphonic_sine_voice_engine_top.sv =====
// Polyphonic sine voice engine.
// Request channel (req_valid / req_stall / req_data) takes note-on, note-off
// and sample-tick commands. A transfer happens when req_valid is high and
// req_stall is low; req_stall is high while a command is being worked on.
// Note-on and note-off walk the voices one per cycle and give no response.
// A tick walks the voices through one shared sine ROM and one 16x17
// multiply-accumulate: a silent voice is skipped after its check, and a
// sounding voice is updated, read from the ROM, multiplied and accumulated
// in turn; after the last voice the output register is loaded.
// A tick gives one response (rsp_valid / rsp_stall / rsp_data) holding the
// saturated Q1.15 mix and the count of sounding voices. If the receiver
// stalls, the response holds in the output register and a following tick
// waits in its output state (ST_OUT) until that response transfers.
// Control registers are written over csr_valid / csr_ready / csr_index /
// csr_data; csr_ready is always high. Writes must be made only while idle;
// the block itself does not enforce this. Synchronous reset clears all voices,
// restores the register defaults and drops any pending response.
module polyphonic_sine_voice_engine_top #(
   parameter int VOICE_COUNT     = psve_pkg::VOICE_COUNT_DEFAULT,
   parameter int PHASE_BITS      = psve_pkg::PHASE_BITS_DEFAULT,
   parameter int SINE_TABLE_BITS = psve_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  psve_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output psve_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [psve_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [psve_pkg::LEVEL_W-1:0]     csr_data
);

   localparam int VI_W    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
   localparam int ACC_W   = 33 + $clog2(VOICE_COUNT + 1);
   localparam int SHIFT_W = ACC_W - 18;
   localparam int PW      = psve_pkg::PITCH_W;
   localparam int LW      = psve_pkg::LEVEL_W;

   localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'(32767);
   localparam logic signed [SHIFT_W-1:0] SAT_LO = SHIFT_W'(-32768);

   typedef enum logic [2:0] {
      ST_IDLE, ST_ON, ST_OFF, ST_VOICE, ST_ROM, ST_MUL, ST_ACC, ST_OUT
   } state_type;

   state_type                       state_ff;
   logic [VI_W-1:0]                 vi_ff;
   logic [PW-1:0]                   pitch_ff;
   logic [psve_pkg::COUNT_W-1:0]    count_ff;
   logic [PW-1:0]                   v_pitch_ff [VOICE_COUNT];
   logic [PHASE_BITS-1:0]           v_phase_ff [VOICE_COUNT];
   logic [LW-1:0]                   v_level_ff [VOICE_COUNT];
   logic [VOICE_COUNT-1:0]          v_held_ff;
   logic [LW-1:0]                   attack_ff;
   logic [LW-1:0]                   release_ff;
   logic [LW-1:0]                   silence_ff;
   logic                            rsp_valid_ff;
   psve_pkg::rsp_type               rsp_data_ff;

   logic                            cur_held;
   logic [LW-1:0]                   cur_level;
   logic [PW-1:0]                   cur_pitch;
   logic [PHASE_BITS-1:0]           cur_phase;
   logic                            is_last;
   logic                            active;
   logic [PHASE_BITS-1:0]           next_phase;
   logic [LW:0]                     attack_sum;
   logic [LW-1:0]                   next_level;
   logic                            next_held;
   logic signed [15:0]              rom_data;
   logic signed [ACC_W-1:0]         acc;
   logic signed [SHIFT_W-1:0]       acc_shift;
   logic signed [psve_pkg::SAMPLE_W-1:0] sample_sat;
   psve_pkg::mac_ctrl_type          mac_ctrl;

   assign cur_held   = v_held_ff[vi_ff];
   assign cur_level  = v_level_ff[vi_ff];
   assign cur_pitch  = v_pitch_ff[vi_ff];
   assign cur_phase  = v_phase_ff[vi_ff];
   assign is_last    = (vi_ff == VI_W'(VOICE_COUNT - 1));
   assign active     = cur_held || (cur_level > silence_ff);
   assign next_phase = cur_phase + PHASE_BITS'(cur_pitch);
   assign attack_sum = {1'b0, cur_level} + {1'b0, attack_ff};

   always_comb begin
      next_held = cur_held;
      if (cur_held) begin
         next_level = attack_sum[LW] ? psve_pkg::LEVEL_FULL : attack_sum[LW-1:0];
      end else if (cur_level < release_ff) begin
         next_level = '0;
         next_held  = 1'b0;
      end else begin
         next_level = cur_level - release_ff;
      end
   end

   assign acc_shift = acc[ACC_W-1:18];

   always_comb begin
      if (acc_shift > SAT_HI) begin
         sample_sat = 16'sh7FFF;
      end else if (acc_shift < SAT_LO) begin
         sample_sat = 16'sh8000;
      end else begin
         sample_sat = acc_shift[15:0];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   assign mac_ctrl.clear  = (state_ff == ST_IDLE) && req_valid;
   assign mac_ctrl.mul_en = (state_ff == ST_MUL);
   assign mac_ctrl.acc_en = (state_ff == ST_ACC);

   psve_sine_rom #(
      .TBL_BITS (SINE_TABLE_BITS)
   ) u_sine_rom (
      .clock    (clock),
      .rd_en    (state_ff == ST_ROM),
      .rd_index (cur_phase[PHASE_BITS-1 -: SINE_TABLE_BITS]),
      .rd_data  (rom_data)
   );

   psve_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .sine  (rom_data),
      .level (cur_level),
      .acc   (acc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vi_ff        <= '0;
         count_ff     <= '0;
         v_held_ff    <= '0;
         attack_ff    <= psve_pkg::ATTACK_STEP_RESET;
         release_ff   <= psve_pkg::RELEASE_STEP_RESET;
         silence_ff   <= psve_pkg::SILENCE_LEVEL_RESET;
         rsp_valid_ff <= 1'b0;
         for (int v = 0; v < VOICE_COUNT; v++) begin
            v_pitch_ff[v] <= '0;
            v_phase_ff[v] <= '0;
            v_level_ff[v] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               psve_pkg::CSR_ATTACK_STEP:   attack_ff  <= csr_data;
               psve_pkg::CSR_RELEASE_STEP:  release_ff <= csr_data;
               psve_pkg::CSR_SILENCE_LEVEL: silence_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  pitch_ff <= req_data.pitch_step;
                  vi_ff    <= '0;
                  count_ff <= '0;
                  case (req_data.mode)
                     psve_pkg::MODE_NOTE_ON:  state_ff <= ST_ON;
                     psve_pkg::MODE_NOTE_OFF: state_ff <= ST_OFF;
                     psve_pkg::MODE_TICK:     state_ff <= ST_VOICE;
                     default:                 state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_ON: begin
               if (!cur_held) begin
                  v_pitch_ff[vi_ff] <= pitch_ff;
                  v_held_ff[vi_ff]  <= 1'b1;
                  v_level_ff[vi_ff] <= '0;
                  state_ff          <= ST_IDLE;
               end else if (is_last) begin
                  v_pitch_ff[0] <= pitch_ff;
                  v_level_ff[0] <= '0;
                  state_ff      <= ST_IDLE;
               end else begin
                  vi_ff <= vi_ff + VI_W'(1);
               end
            end
            ST_OFF: begin
               if (cur_held && (cur_pitch == pitch_ff)) begin
                  v_held_ff[vi_ff] <= 1'b0;
                  state_ff         <= ST_IDLE;
               end else if (is_last) begin
                  state_ff <= ST_IDLE;
               end else begin
                  vi_ff <= vi_ff + VI_W'(1);
               end
            end
            ST_VOICE: begin
               if (active) begin
                  v_phase_ff[vi_ff] <= next_phase;
                  v_level_ff[vi_ff] <= next_level;
                  v_held_ff[vi_ff]  <= next_held;
                  if (count_ff != psve_pkg::COUNT_MAX) begin
                     count_ff <= count_ff + psve_pkg::COUNT_W'(1);
                  end
                  state_ff <= ST_ROM;
               end else if (is_last) begin
                  state_ff <= ST_OUT;
               end else begin
                  vi_ff <= vi_ff + VI_W'(1);
               end
            end
            ST_ROM: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (is_last) begin
                  state_ff <= ST_OUT;
               end else begin
                  vi_ff    <= vi_ff + VI_W'(1);
                  state_ff <= ST_VOICE;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_data_ff.sample        <= sample_sat;
                  rsp_data_ff.active_voices <= count_ff;
                  rsp_valid_ff              <= 1'b1;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== hdl/psve_sine_rom.sv =====
module psve_sine_rom #(
   parameter int TBL_BITS = psve_pkg::SINE_TABLE_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [TBL_BITS-1:0] rd_index,
   output logic signed [15:0]  rd_data
);

   localparam int QUARTER = 2 ** (TBL_BITS - 2);
   localparam int ADDR_W  = TBL_BITS - 1;

   logic [15:0]             quarter_rom [QUARTER+1];
   logic [1:0]              quad;
   logic [TBL_BITS-3:0]     offset;
   logic [ADDR_W-1:0]       addr;
   logic signed [15:0]      mag;
   logic signed [15:0]      rd_data_ff;

   for (genvar i = 0; i <= QUARTER; i++) begin : g_rom
      assign quarter_rom[i] = psve_pkg::sine_quarter(i, TBL_BITS);
   end

   assign quad   = rd_index[TBL_BITS-1 -: 2];
   assign offset = rd_index[TBL_BITS-3:0];
   assign addr   = quad[0] ? (ADDR_W'(QUARTER) - {1'b0, offset}) : {1'b0, offset};
   assign mag    = $signed(quarter_rom[addr]);

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= quad[1] ? -mag : mag;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/psve_mac.sv =====
module psve_mac #(
   parameter int ACC_W = 36
) (
   input  logic                         clock,
   input  psve_pkg::mac_ctrl_type       ctrl,
   input  logic signed [15:0]           sine,
   input  logic [psve_pkg::LEVEL_W-1:0] level,
   output logic signed [ACC_W-1:0]      acc
);

   logic signed [32:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= 33'(sine * $signed({1'b0, level}));
      end
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (ctrl.acc_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   assign acc = acc_ff;

endmodule

// ===== hdl/psve_checker.sv =====
module psve_checker #(
   parameter int VOICE_COUNT = psve_pkg::VOICE_COUNT_DEFAULT
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input psve_pkg::req_type                req_data,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input psve_pkg::rsp_type                rsp_data
);

   localparam int MAX_COUNT = (VOICE_COUNT > 7) ? 7 : VOICE_COUNT;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.active_voices <= psve_pkg::COUNT_W'(MAX_COUNT))
      else $error("active voice count out of range");

   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.mode == psve_pkg::MODE_NOTE_ON ||
      req_data.mode == psve_pkg::MODE_NOTE_OFF ||
      req_data.mode == psve_pkg::MODE_TICK) |=> req_stall)
      else $error("command transfer not followed by busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a tick in progress");

endmodule

bind polyphonic_sine_voice_engine_top psve_checker #(
   .VOICE_COUNT (VOICE_COUNT)
) u_psve_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
